>>> rtl/swbl_pkg.sv
// Shared types, codes and constant tables for the single-wire backlight step control.
package swbl_pkg;

  localparam int LEVEL_W = 8;
  localparam int STEP_W  = 5;
  localparam int PCT_W   = 7;
  localparam int ACT_W   = 3;
  localparam int PROD_W  = 16;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic {
    MODE_LEVEL = 1'b0,
    MODE_TEST  = 1'b1
  } mode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE  = 3'd0,
    ACT_OFF   = 3'd1,
    ACT_LONG  = 3'd2,
    ACT_SHORT = 3'd3,
    ACT_BOOT  = 3'd4,
    ACT_TEST  = 3'd5
  } action_t;

  typedef struct packed {
    logic [STEP_W-1:0]  raw_steps;
    logic [LEVEL_W-1:0] level;
    mode_t              mode;
  } req_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] saved_level;
    logic [STEP_W-1:0]  pulse_count;
    action_t            action;
  } res_t;

  localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

  // dimmer step for each percent value 0..100
  localparam logic [STEP_W-1:0] STEP_OF_PCT [0:100] = '{
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd31,
    5'd31, 5'd31, 5'd31, 5'd31, 5'd31, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30, 5'd30,
    5'd30, 5'd30, 5'd30, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29, 5'd29,
    5'd29, 5'd29, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd27, 5'd27,
    5'd27, 5'd27, 5'd26, 5'd26, 5'd26, 5'd26, 5'd25, 5'd25, 5'd25, 5'd24,
    5'd24, 5'd23, 5'd23, 5'd23, 5'd22, 5'd22, 5'd22, 5'd21, 5'd21, 5'd20,
    5'd20, 5'd20, 5'd19, 5'd19, 5'd19, 5'd18, 5'd18, 5'd17, 5'd17, 5'd16,
    5'd15, 5'd15, 5'd15, 5'd14, 5'd14, 5'd13, 5'd13, 5'd12, 5'd12, 5'd11,
    5'd10, 5'd9,  5'd9,  5'd8,  5'd8,  5'd7,  5'd7,  5'd6,  5'd5,  5'd4,
    5'd3
  };

  // level reported back after a raw step write in test mode
  localparam logic [LEVEL_W-1:0] LEVEL_OF_STEPS [0:31] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd249, 8'd247, 8'd244,
    8'd239, 8'd234, 8'd229, 8'd226, 8'd224, 8'd219, 8'd214, 8'd209,
    8'd201, 8'd198, 8'd193, 8'd188, 8'd181, 8'd173, 8'd168, 8'd160,
    8'd153, 8'd147, 8'd140, 8'd130, 8'd119, 8'd104, 8'd81,  8'd35
  };

  function automatic logic [STEP_W-1:0] step_of_pct(input logic [PCT_W-1:0] pct);
    logic [STEP_W-1:0] s;
    if (pct > PCT_MAX) begin
      s = STEP_OF_PCT[100];
    end else begin
      s = STEP_OF_PCT[pct];
    end
    return s;
  endfunction

endpackage

>>> rtl/single_wire_backlight_step_control.sv
// Top level of the single-wire pulse-count backlight step control.
//
//   channel | dir | fields (tdata, low bit first)                  | handshake
//   --------+-----+------------------------------------------------+-----------
//   in_     | in  | mode[0], level[8:1], raw_steps[13:9], pad      | tvalid/tready
//   out_    | out | action[2:0], pulse_count[7:3], saved_level[15:8]| tvalid/tready
//
// One word per cycle sustained while the sink takes every word; an accepted word
// passes the input register, then decision logic into the output register.
// The remembered level, step and boot flag update as a word leaves the input
// register, so back-to-back words see the state left by the one before.
// rst_n is synchronous, active low: clears valids, state, boot flag.
// A stalled output holds both stages; the input register frees as soon as
// the output register can take its word in the same cycle.
module single_wire_backlight_step_control (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // mode[0], level[8:1], raw_steps[13:9], zero[15:14]
  input  logic [swbl_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // action[2:0], pulse_count[7:3], saved_level[15:8]
  output logic [swbl_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import swbl_pkg::*;

  req_t in_req;
  req_t req;
  res_t res;
  res_t out_res;
  logic req_valid;
  logic adv;
  logic fire;

  // unpack input word; bits above raw_steps are padding
  assign in_req.mode      = mode_t'(in_tdata[0]);
  assign in_req.level     = in_tdata[8:1];
  assign in_req.raw_steps = in_tdata[13:9];

  // pipeline moves when the output register is free or being drained
  assign adv  = !out_tvalid || out_tready;
  assign fire = req_valid && adv;

  swbl_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_req    (in_req),
    .adv       (adv),
    .req_valid (req_valid),
    .req       (req)
  );

  swbl_decide u_decide (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res)
  );

  swbl_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .res_valid  (req_valid),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_res    (out_res)
  );

  assign out_tdata = OUT_TDATA_W'(out_res);

`ifndef SYNTHESIS
  // turning off never sends pulses and forgets the level
  a_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.action == ACT_OFF) |->
      (out_res.pulse_count == '0) && (out_res.saved_level == '0))
    else $error("off word carries pulses or a level");

  // no-change word carries no pulses
  a_none_no_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.action == ACT_NONE) |-> (out_res.pulse_count == '0))
    else $error("none word carries pulses");

  // test mode always derives a nonzero level from the step table
  a_test_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_res.action == ACT_TEST) |-> (out_res.saved_level != '0))
    else $error("test word derived level zero");

  // input side only backs up while the output is stalled with a word held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready && req_valid)
    else $error("input stalled without output backpressure");
`endif

endmodule

>>> rtl/swbl_in_stage.sv
// Input register stage: holds one request word until the decision stage takes it.
module swbl_in_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  swbl_pkg::req_t in_req,
  input  logic          adv,
  output logic          req_valid,
  output swbl_pkg::req_t req
);
  import swbl_pkg::*;

  logic in_valid_r;
  logic in_valid_nxt;
  req_t in_req_r;

  assign in_tready = !in_valid_r || adv;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tready) begin
      in_valid_nxt = in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_req_r <= in_req;
    end
  end

  assign req_valid = in_valid_r;
  assign req       = in_req_r;

endmodule

>>> rtl/swbl_decide.sv
// Command decision logic and the remembered level / step / boot state.
module swbl_decide (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  swbl_pkg::req_t req,
  output swbl_pkg::res_t res
);
  import swbl_pkg::*;

  logic [LEVEL_W-1:0] last_level_r, last_level_nxt;
  logic [STEP_W-1:0]  last_steps_r, last_steps_nxt;
  logic               boot_done_r,  boot_done_nxt;

  logic [PROD_W-1:0]  prod;
  logic [PROD_W-1:0]  quot;
  logic [PCT_W-1:0]   pct;
  logic [STEP_W-1:0]  cur;
  logic [STEP_W-1:0]  cnt;
  logic               equal;

  // pct = level*100/255, via x/255 = (x + (x >> 8) + 1) >> 8 for x up to 255*100
  assign prod  = PROD_W'(req.level) * PROD_W'(100);
  assign quot  = (prod + (prod >> 8) + PROD_W'(1)) >> 8;
  assign pct   = quot[PCT_W-1:0];
  assign cur   = step_of_pct(pct);
  // 5-bit wrap gives the modulo-32 step distance in both directions
  assign cnt   = (last_level_r == '0) ? cur : (cur - last_steps_r);
  assign equal = (last_level_r != '0) && (last_steps_r == cur);

  always_comb begin
    last_level_nxt  = last_level_r;
    last_steps_nxt  = last_steps_r;
    boot_done_nxt   = boot_done_r;
    res.action      = ACT_NONE;
    res.pulse_count = '0;
    if (req.mode == MODE_TEST) begin
      res.action      = ACT_TEST;
      res.pulse_count = req.raw_steps;
      last_steps_nxt  = req.raw_steps;
      last_level_nxt  = LEVEL_OF_STEPS[req.raw_steps];
    end else if (req.level == '0) begin
      res.action     = ACT_OFF;
      last_level_nxt = '0;
      last_steps_nxt = '0;
    end else if (req.level != last_level_r) begin
      if (!equal) begin
        if (!boot_done_r) begin
          boot_done_nxt = 1'b1;
          if (cnt != '0 && cur != '0) begin
            res.action      = ACT_BOOT;
            res.pulse_count = cnt;
          end
        end else begin
          res.action = (last_level_r != '0) ? ACT_SHORT : ACT_LONG;
          if (cnt != '0 && last_steps_r != cur) begin
            res.pulse_count = cnt;
          end
        end
      end
      last_level_nxt = req.level;
      last_steps_nxt = cur;
    end
    res.saved_level = last_level_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_level_r <= '0;
      last_steps_r <= '0;
      boot_done_r  <= 1'b0;
    end else if (fire) begin
      last_level_r <= last_level_nxt;
      last_steps_r <= last_steps_nxt;
      boot_done_r  <= boot_done_nxt;
    end
  end

endmodule

>>> rtl/swbl_out_stage.sv
// Output register stage: holds one result word until the sink takes it.
module swbl_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           res_valid,
  input  swbl_pkg::res_t res,
  output logic           out_tvalid,
  output swbl_pkg::res_t out_res
);
  import swbl_pkg::*;

  logic out_valid_r;
  logic out_valid_nxt;
  res_t out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_res    = out_res_r;

endmodule
